// File: rtl/tad_pkg.sv
// Package for the triangle drag pipeline: field widths, word types, register
// indexes and small helper functions shared by the pipeline sections.
// No dependencies.
`default_nettype none

package tad_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 10;
  localparam int WORD_BITS  = 3 * COORD_BITS;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int SUM_W   = COORD_BITS + 3;
  localparam int CMAG_W  = 2 * EDGE_W;
  localparam int SS_W    = 2 * SUM_W + 2;
  localparam int NORM_W  = 30;
  localparam int LEN_W   = $clog2(CMAG_W + 1);
  localparam int ROOT_W  = 64;
  localparam int SS_SHIFT = 16;
  localparam int R_W     = NORM_W + 1;
  localparam int W_W     = 32;
  localparam int U_W     = NORM_W + 1;
  localparam int DRAG_W  = 16;
  localparam int EXP_W   = 10;
  localparam int E_BIAS  = NORM_W + 2 * FRAC_BITS + 16 + 1 + (30 + FRAC_BITS)
                           + (FRAC_BITS + 8) + 30;

  localparam int REG_W = 8;
  localparam logic [REG_W-1:0] REG_WIND = 8'd0;
  localparam logic [REG_W-1:0] REG_DRAG = 8'd1;

  localparam logic [WORD_BITS-1:0] WIND_RESET = 60'd1125899906842624;
  localparam logic [DRAG_W-1:0]    DRAG_RESET = 16'd6554;

  typedef struct packed {
    logic [WORD_BITS-1:0] p1_position;
    logic [WORD_BITS-1:0] p1_velocity;
    logic [WORD_BITS-1:0] p2_position;
    logic [WORD_BITS-1:0] p2_velocity;
    logic [WORD_BITS-1:0] p3_position;
    logic [WORD_BITS-1:0] p3_velocity;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               degenerate;
    logic               saturated;
  } out_word_t;

  typedef struct packed {
    logic                        degen;
    logic [2:0]                  cneg;
    logic [2:0][NORM_W-1:0]      cm;
    logic [LEN_W-1:0]            len;
    logic [2:0][SUM_W-1:0]       s;
  } ctx_t;

  function automatic logic signed [COORD_BITS-1:0] coord(logic [WORD_BITS-1:0] w, int i);
    return $signed(w[i*COORD_BITS +: COORD_BITS]);
  endfunction

  function automatic logic [6:0] bitlen64(logic [63:0] x);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [5:0] cut_shift(logic [63:0] x);
    logic [6:0] n;
    n = bitlen64(x);
    return (n > 7'd32) ? 6'(n - 7'd32) : 6'd0;
  endfunction

endpackage

`default_nettype wire

// File: rtl/tad_front.sv
// Front section: edges, summed velocity, cross product, normalization of the
// normal and the two sums of squares. Seven register stages.
// Depends on tad_pkg.
`default_nettype none

module tad_front import tad_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  in_word_t             word_i,
  input  logic [WORD_BITS-1:0] wind_i,
  output logic                 vld_o,
  output ctx_t                 ctx_o,
  output logic [ROOT_W-1:0]    q_o,
  output logic [ROOT_W-1:0]    ss_o
);

  logic [6:0] vld_r;

  logic signed [EDGE_W-1:0]   e1_r [3], e2_r [3], e1_nxt [3], e2_nxt [3];
  logic signed [SUM_W-1:0]    s1_r [3], s1_nxt [3];
  logic signed [CMAG_W-1:0]   pr_r [6], pr_nxt [6];
  logic signed [2*SUM_W-1:0]  sq_r [3], sq_nxt [3];
  logic signed [SUM_W-1:0]    s2_r [3], s3_r [3], s4_r [3];
  logic [CMAG_W-1:0]          mag3_r [3], mag3_nxt [3], mag4_r [3];
  logic [2:0]                 neg3_r, neg3_nxt, neg4_r;
  logic [SS_W-1:0]            ss3_r, ss3_nxt, ss4_r, ss5_r, ss6_r, ss7_r;
  logic [LEN_W-1:0]           len4_r, len4_nxt;
  logic                       degen4_r, degen4_nxt;
  ctx_t                       ctx5_r, ctx5_nxt, ctx6_r, ctx7_r;
  logic [2*NORM_W-1:0]        csq6_r [3], csq6_nxt [3];
  logic [2*NORM_W+1:0]        q7_r, q7_nxt;

  always_comb begin
    logic signed [COORD_BITS-1:0] a, b, c, va, vb, vc, wv;
    for (int i = 0; i < 3; i++) begin
      a  = coord(word_i.p1_position, i);
      b  = coord(word_i.p2_position, i);
      c  = coord(word_i.p3_position, i);
      va = coord(word_i.p1_velocity, i);
      vb = coord(word_i.p2_velocity, i);
      vc = coord(word_i.p3_velocity, i);
      wv = coord(wind_i, i);
      e1_nxt[i] = EDGE_W'(b) - EDGE_W'(a);
      e2_nxt[i] = EDGE_W'(c) - EDGE_W'(a);
      s1_nxt[i] = SUM_W'(va) + SUM_W'(vb) + SUM_W'(vc)
                  - (SUM_W'(wv) <<< 1) - SUM_W'(wv);
    end
  end

  always_comb begin
    pr_nxt[0] = e1_r[1] * e2_r[2];
    pr_nxt[1] = e1_r[2] * e2_r[1];
    pr_nxt[2] = e1_r[2] * e2_r[0];
    pr_nxt[3] = e1_r[0] * e2_r[2];
    pr_nxt[4] = e1_r[0] * e2_r[1];
    pr_nxt[5] = e1_r[1] * e2_r[0];
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = s1_r[i] * s1_r[i];
    end
  end

  always_comb begin
    logic signed [CMAG_W:0] cv;
    ss3_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      cv = (CMAG_W+1)'(pr_r[2*i]) - (CMAG_W+1)'(pr_r[2*i+1]);
      neg3_nxt[i] = cv[CMAG_W];
      mag3_nxt[i] = cv[CMAG_W] ? CMAG_W'(-cv) : CMAG_W'(cv);
      ss3_nxt = ss3_nxt + SS_W'($unsigned(sq_r[i]));
    end
  end

  always_comb begin
    logic [CMAG_W-1:0] orv;
    orv = mag3_r[0] | mag3_r[1] | mag3_r[2];
    len4_nxt   = LEN_W'(bitlen64(64'(orv)));
    degen4_nxt = (orv == '0);
  end

  always_comb begin
    ctx5_nxt.degen = degen4_r;
    ctx5_nxt.cneg  = neg4_r;
    ctx5_nxt.len   = len4_r;
    for (int i = 0; i < 3; i++) begin
      ctx5_nxt.s[i] = s4_r[i];
      if (len4_r > LEN_W'(NORM_W)) begin
        ctx5_nxt.cm[i] = NORM_W'(mag4_r[i] >> (len4_r - LEN_W'(NORM_W)));
      end else begin
        ctx5_nxt.cm[i] = NORM_W'(mag4_r[i] << (LEN_W'(NORM_W) - len4_r));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csq6_nxt[i] = ctx5_r.cm[i] * ctx5_r.cm[i];
    end
    q7_nxt = (2*NORM_W+2)'(csq6_r[0]) + (2*NORM_W+2)'(csq6_r[1])
           + (2*NORM_W+2)'(csq6_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r     <= e1_nxt;
      e2_r     <= e2_nxt;
      s1_r     <= s1_nxt;
      pr_r     <= pr_nxt;
      sq_r     <= sq_nxt;
      s2_r     <= s1_r;
      mag3_r   <= mag3_nxt;
      neg3_r   <= neg3_nxt;
      ss3_r    <= ss3_nxt;
      s3_r     <= s2_r;
      mag4_r   <= mag3_r;
      neg4_r   <= neg3_r;
      len4_r   <= len4_nxt;
      degen4_r <= degen4_nxt;
      ss4_r    <= ss3_r;
      s4_r     <= s3_r;
      ctx5_r   <= ctx5_nxt;
      ss5_r    <= ss4_r;
      csq6_r   <= csq6_nxt;
      ctx6_r   <= ctx5_r;
      ss6_r    <= ss5_r;
      q7_r     <= q7_nxt;
      ctx7_r   <= ctx6_r;
      ss7_r    <= ss6_r;
    end
  end

  assign vld_o = vld_r[6];
  assign ctx_o = ctx7_r;
  assign q_o   = ROOT_W'(q7_r);
  assign ss_o  = ROOT_W'({ss7_r, {SS_SHIFT{1'b0}}});

endmodule

`default_nettype wire

// File: rtl/tad_root.sv
// Two-lane pipelined integer square root, one result bit per stage, for the
// cross product length and the relative speed. Depends on tad_pkg.
`default_nettype none

module tad_root import tad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  ctx_t              ctx_i,
  input  logic [ROOT_W-1:0] q_i,
  input  logic [ROOT_W-1:0] ss_i,
  output logic              vld_o,
  output ctx_t              ctx_o,
  output logic [R_W-1:0]    r_o,
  output logic [W_W-1:0]    w_o
);

  localparam int STEPS = ROOT_W / 2;

  typedef struct packed {
    logic [ROOT_W-1:0] x;
    logic [ROOT_W-1:0] res;
  } root_t;

  function automatic root_t sqrt_step(root_t a, logic [ROOT_W-1:0] one);
    root_t o;
    logic [ROOT_W-1:0] t;
    t = a.res + one;
    if (a.x >= t) begin
      o.x   = a.x - t;
      o.res = (a.res >> 1) + one;
    end else begin
      o.x   = a.x;
      o.res = a.res >> 1;
    end
    return o;
  endfunction

  logic [STEPS-1:0] vld_r;
  root_t            qa_r [STEPS];
  root_t            sa_r [STEPS];
  ctx_t             ctx_r [STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r[0]  <= sqrt_step('{x: q_i, res: '0}, ROOT_W'(1) << (ROOT_W - 2));
      sa_r[0]  <= sqrt_step('{x: ss_i, res: '0}, ROOT_W'(1) << (ROOT_W - 2));
      ctx_r[0] <= ctx_i;
      for (int k = 1; k < STEPS; k++) begin
        qa_r[k]  <= sqrt_step(qa_r[k-1], ROOT_W'(1) << (ROOT_W - 2 - 2*k));
        sa_r[k]  <= sqrt_step(sa_r[k-1], ROOT_W'(1) << (ROOT_W - 2 - 2*k));
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  assign vld_o = vld_r[STEPS-1];
  assign ctx_o = ctx_r[STEPS-1];
  assign r_o   = R_W'(qa_r[STEPS-1].res);
  assign w_o   = W_W'(sa_r[STEPS-1].res);

endmodule

`default_nettype wire

// File: rtl/tad_udiv.sv
// Three-lane pipelined restoring divider that forms the unit normal in Q1.30,
// one quotient bit per stage. Depends on tad_pkg.
`default_nettype none

module tad_udiv import tad_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  ctx_t                 ctx_i,
  input  logic [R_W-1:0]       r_i,
  input  logic [W_W-1:0]       w_i,
  output logic                 vld_o,
  output ctx_t                 ctx_o,
  output logic [R_W-1:0]       r_o,
  output logic [W_W-1:0]       w_o,
  output logic [2:0][U_W-1:0]  um_o
);

  localparam int STEPS = U_W;

  typedef struct packed {
    logic [R_W:0]   rem;
    logic [U_W-1:0] quo;
  } div_t;

  function automatic div_t div_step(div_t a, logic nb, logic [R_W-1:0] d);
    div_t o;
    logic [R_W:0] t;
    t = {a.rem[R_W-1:0], nb};
    if (t >= {1'b0, d}) begin
      o.rem = t - {1'b0, d};
      o.quo = {a.quo[U_W-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {a.quo[U_W-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [STEPS-1:0] vld_r;
  div_t             dv_r [STEPS][3];
  ctx_t             ctx_r [STEPS];
  logic [R_W-1:0]   r_r [STEPS];
  logic [W_W-1:0]   w_r [STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i] <= div_step('{rem: (R_W+1)'(ctx_i.cm[i] >> 1), quo: '0},
                               ctx_i.cm[i][0], r_i);
      end
      ctx_r[0] <= ctx_i;
      r_r[0]   <= r_i;
      w_r[0]   <= w_i;
      for (int k = 1; k < STEPS; k++) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[k][i] <= div_step(dv_r[k-1][i], 1'b0, r_r[k-1]);
        end
        ctx_r[k] <= ctx_r[k-1];
        r_r[k]   <= r_r[k-1];
        w_r[k]   <= w_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      um_o[i] = dv_r[STEPS-1][i].quo;
    end
  end

  assign vld_o = vld_r[STEPS-1];
  assign ctx_o = ctx_r[STEPS-1];
  assign r_o   = r_r[STEPS-1];
  assign w_o   = w_r[STEPS-1];

endmodule

`default_nettype wire

// File: rtl/tad_scale.sv
// Back section: dot product, drag magnitude as a mantissa with an exponent,
// division by nine, per-axis force and saturation. Eighteen register stages,
// the last one being the output register. Depends on tad_pkg.
`default_nettype none

module tad_scale import tad_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [DRAG_W-1:0]   drag_i,
  input  logic                vld_i,
  input  ctx_t                ctx_i,
  input  logic [R_W-1:0]      r_i,
  input  logic [W_W-1:0]      w_i,
  input  logic [2:0][U_W-1:0] um_i,
  output logic                vld_o,
  output out_word_t           word_o
);

  localparam int UP_W   = U_W + SUM_W + 1;
  localparam int D_W    = UP_W + 1;
  localparam int A_W    = DRAG_W + R_W;
  localparam int P_W    = 32 + U_W;
  localparam int DIV_ST = 8;

  typedef struct packed {
    logic                    degen;
    logic                    zr;
    logic                    dneg;
    logic [2:0]              cneg;
    logic [2:0][U_W-1:0]     um;
    logic [W_W-1:0]          w;
    logic signed [EXP_W-1:0] e;
  } tail_t;

  function automatic logic [7:0] div9_digit(logic [7:0] v);
    logic [3:0] q;
    logic [7:0] rv;
    q = 4'd0;
    for (int j = 1; j < 16; j++) begin
      if (v >= 8'(9 * j)) q = 4'(j);
    end
    rv = v - (({4'd0, q} << 3) + {4'd0, q});
    return {q, rv[3:0]};
  endfunction

  function automatic logic [11:0] div_byte(logic [3:0] rm, logic [7:0] by);
    logic [7:0] d1, d2;
    d1 = div9_digit({rm, by[7:4]});
    d2 = div9_digit({d1[3:0], by[3:0]});
    return {d1[7:4], d2[7:4], d2[3:0]};
  endfunction

  function automatic logic [32:0] sat_q16(logic [P_W-1:0] p, logic neg,
                                          logic signed [EXP_W-1:0] t);
    logic [31:0]      lim, mag;
    logic             sat;
    logic [EXP_W-1:0] nt;
    logic [P_W-1:0]   sh;
    lim = neg ? 32'h8000_0000 : 32'h7fff_ffff;
    sat = 1'b0;
    mag = '0;
    nt  = '0;
    sh  = '0;
    if (p != '0) begin
      if (t >= 0) begin
        if (t >= 32 || p > P_W'(lim >> t[4:0])) begin
          mag = lim;
          sat = 1'b1;
        end else begin
          mag = 32'(p << t[4:0]);
        end
      end else begin
        nt = EXP_W'(-t);
        sh = (nt >= EXP_W'(64)) ? '0 : (p >> nt[5:0]);
        if (sh > P_W'(lim)) begin
          mag = lim;
          sat = 1'b1;
        end else begin
          mag = 32'(sh);
        end
      end
    end
    return {sat, neg ? 32'(-mag) : mag};
  endfunction

  logic [17:0] vld_r;

  logic signed [UP_W-1:0] up1_r [3], up1_nxt [3];
  logic [A_W-1:0]         a1_r, a2_r;
  logic                   degen1_r, degen2_r;
  logic [2:0]             cneg1_r, cneg2_r;
  logic [LEN_W-1:0]       len1_r, len2_r;
  logic [2:0][U_W-1:0]    um1_r, um2_r;
  logic [W_W-1:0]         w1_r, w2_r;
  logic signed [D_W-1:0]  d2_r, d2_nxt;

  tail_t                  t3_r, t3_nxt, t4_r, t4_nxt, t5_r, t14_r, t14_nxt;
  tail_t                  t15_r, t16_r, t16_nxt, t17_r;
  logic [31:0]            a3_r, a3_nxt, a4_r, b4_r, b4_nxt;
  logic [D_W-2:0]         dm3_r, dm3_nxt;
  logic [63:0]            m5_r, m15_r;
  logic [63:0]            x_r [DIV_ST], q_r [DIV_ST];
  logic [3:0]             rm_r [DIV_ST];
  tail_t                  td_r [DIV_ST];
  logic [11:0]            byte_res [DIV_ST];
  logic [31:0]            a14_r, a14_nxt, a16_r, a16_nxt;
  logic [P_W-1:0]         p17_r [3];
  out_word_t              out_r, out_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up1_nxt[i] = $signed({1'b0, um_i[i]}) * $signed(ctx_i.s[i]);
    end
  end

  always_comb begin
    logic signed [D_W-1:0] term;
    d2_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      term = D_W'(up1_r[i]);
      if (cneg1_r[i]) term = -term;
      d2_nxt = d2_nxt + term;
    end
  end

  always_comb begin
    logic [5:0] sh;
    sh = cut_shift(64'(a2_r));
    a3_nxt = 32'(a2_r >> sh);
    dm3_nxt = d2_r[D_W-1] ? (D_W-1)'(-d2_r) : (D_W-1)'(d2_r);
    t3_nxt.degen = degen2_r;
    t3_nxt.zr    = (d2_r == '0) || (w2_r == '0);
    t3_nxt.dneg  = d2_r[D_W-1];
    t3_nxt.cneg  = cneg2_r;
    t3_nxt.um    = um2_r;
    t3_nxt.w     = w2_r;
    t3_nxt.e     = EXP_W'(len2_r) - EXP_W'(E_BIAS) + EXP_W'(sh);
  end

  always_comb begin
    logic [5:0] sh;
    sh = cut_shift(64'(dm3_r));
    b4_nxt = 32'(dm3_r >> sh);
    t4_nxt = t3_r;
    t4_nxt.e = t3_r.e + EXP_W'(sh);
  end

  always_comb begin
    byte_res[0] = div_byte(4'd0, m5_r[63:56]);
    for (int j = 1; j < DIV_ST; j++) begin
      byte_res[j] = div_byte(rm_r[j-1], x_r[j-1][63:56]);
    end
  end

  always_comb begin
    logic [5:0] sh;
    sh = cut_shift(q_r[DIV_ST-1]);
    a14_nxt = 32'(q_r[DIV_ST-1] >> sh);
    t14_nxt = td_r[DIV_ST-1];
    t14_nxt.e = td_r[DIV_ST-1].e + EXP_W'(sh);
  end

  always_comb begin
    logic [5:0] sh;
    sh = cut_shift(m15_r);
    a16_nxt = 32'(m15_r >> sh);
    t16_nxt = t15_r;
    t16_nxt.e = t15_r.e + EXP_W'(sh);
  end

  always_comb begin
    logic [32:0]             fx, fy, fz;
    logic signed [EXP_W-1:0] tt;
    logic [2:0]              neg;
    tt = t17_r.e + EXP_W'(16);
    for (int i = 0; i < 3; i++) begin
      neg[i] = (t17_r.um[i] != '0) && (t17_r.dneg == t17_r.cneg[i]);
    end
    fx = sat_q16(p17_r[0], neg[0], tt);
    fy = sat_q16(p17_r[1], neg[1], tt);
    fz = sat_q16(p17_r[2], neg[2], tt);
    out_nxt.degenerate = t17_r.degen;
    if (t17_r.degen || t17_r.zr) begin
      out_nxt.force_x   = '0;
      out_nxt.force_y   = '0;
      out_nxt.force_z   = '0;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.force_x   = $signed(fx[31:0]);
      out_nxt.force_y   = $signed(fy[31:0]);
      out_nxt.force_z   = $signed(fz[31:0]);
      out_nxt.saturated = fx[32] | fy[32] | fz[32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[16:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up1_r    <= up1_nxt;
      a1_r     <= drag_i * r_i;
      degen1_r <= ctx_i.degen;
      cneg1_r  <= ctx_i.cneg;
      len1_r   <= ctx_i.len;
      um1_r    <= um_i;
      w1_r     <= w_i;
      d2_r     <= d2_nxt;
      a2_r     <= a1_r;
      degen2_r <= degen1_r;
      cneg2_r  <= cneg1_r;
      len2_r   <= len1_r;
      um2_r    <= um1_r;
      w2_r     <= w1_r;
      t3_r     <= t3_nxt;
      a3_r     <= a3_nxt;
      dm3_r    <= dm3_nxt;
      t4_r     <= t4_nxt;
      a4_r     <= a3_r;
      b4_r     <= b4_nxt;
      m5_r     <= a4_r * b4_r;
      t5_r     <= t4_r;
      x_r[0]   <= m5_r << 8;
      q_r[0]   <= {56'd0, byte_res[0][11:4]};
      rm_r[0]  <= byte_res[0][3:0];
      td_r[0]  <= t5_r;
      for (int j = 1; j < DIV_ST; j++) begin
        x_r[j]  <= x_r[j-1] << 8;
        q_r[j]  <= {q_r[j-1][55:0], byte_res[j][11:4]};
        rm_r[j] <= byte_res[j][3:0];
        td_r[j] <= td_r[j-1];
      end
      a14_r    <= a14_nxt;
      t14_r    <= t14_nxt;
      m15_r    <= a14_r * t14_r.w;
      t15_r    <= t14_r;
      a16_r    <= a16_nxt;
      t16_r    <= t16_nxt;
      for (int i = 0; i < 3; i++) begin
        p17_r[i] <= a16_r * t16_r.um[i];
      end
      t17_r    <= t16_r;
      out_r    <= out_nxt;
    end
  end

  assign vld_o  = vld_r[17];
  assign word_o = out_r;

endmodule

`default_nettype wire

// File: rtl/triangle_aerodynamic_drag.sv
// Drag force on one cloth triangle. A word of three vertex positions and
// velocities enters on in_data and one force word leaves on out_data. The
// pipeline takes one word every cycle unless out_stall holds a waiting
// result; most of its depth lies in the two 32-stage square roots and the
// 31-stage normal divider that run one bit per stage. When out_stall holds a
// waiting result the whole pipeline holds and in_stall rises in the same
// cycle. The wind and drag registers are written through the cfg port, which
// never stalls, and should only be changed while no word is in flight.
`default_nettype none

module triangle_aerodynamic_drag import tad_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_W-1:0]     cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  logic                 en;
  logic [WORD_BITS-1:0] wind_r;
  logic [DRAG_W-1:0]    drag_r;

  logic                 f_vld, rt_vld, dv_vld;
  ctx_t                 f_ctx, rt_ctx, dv_ctx;
  logic [ROOT_W-1:0]    f_q, f_ss;
  logic [R_W-1:0]       rt_r, dv_r;
  logic [W_W-1:0]       rt_w, dv_w;
  logic [2:0][U_W-1:0]  dv_um;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wind_r <= WIND_RESET;
      drag_r <= DRAG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIND: wind_r <= cfg_data;
        REG_DRAG: drag_r <= cfg_data[DRAG_W-1:0];
        default: ;
      endcase
    end
  end

  tad_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .word_i (in_data),
    .wind_i (wind_r),
    .vld_o  (f_vld),
    .ctx_o  (f_ctx),
    .q_o    (f_q),
    .ss_o   (f_ss)
  );

  tad_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (f_vld),
    .ctx_i (f_ctx),
    .q_i   (f_q),
    .ss_i  (f_ss),
    .vld_o (rt_vld),
    .ctx_o (rt_ctx),
    .r_o   (rt_r),
    .w_o   (rt_w)
  );

  tad_udiv u_udiv (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (rt_vld),
    .ctx_i (rt_ctx),
    .r_i   (rt_r),
    .w_i   (rt_w),
    .vld_o (dv_vld),
    .ctx_o (dv_ctx),
    .r_o   (dv_r),
    .w_o   (dv_w),
    .um_o  (dv_um)
  );

  tad_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .drag_i (drag_r),
    .vld_i  (dv_vld),
    .ctx_i  (dv_ctx),
    .r_i    (dv_r),
    .w_i    (dv_w),
    .um_i   (dv_um),
    .vld_o  (out_valid),
    .word_o (out_data)
  );

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.force_x == 0 && out_data.force_y == 0 && out_data.force_z == 0
      && !out_data.saturated)
    else $error("degenerate triangle with nonzero force");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      out_data.force_x == 32'sh7fffffff || out_data.force_x == 32'sh80000000 ||
      out_data.force_y == 32'sh7fffffff || out_data.force_y == 32'sh80000000 ||
      out_data.force_z == 32'sh7fffffff || out_data.force_z == 32'sh80000000)
    else $error("saturated flag without a clamped component");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire
